// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified property checks used by the RTL datapath.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define ASSERT_AT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition");

`endif

// ===== rtl/core/plst_pkg.sv =====
// ---------------------------------------------------------------------------
// Positional list store package
// Sizes, operation and status codes, controller types.
// ---------------------------------------------------------------------------
`default_nettype none

package plst_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int POS_W      = 5;
  localparam int VAL_W      = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ERASE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic modify;
    logic emit_read;
  } ctl_cmd_t;

  typedef struct packed {
    logic read_ok;
    logic read_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/plst_ctrl.sv =====
// ---------------------------------------------------------------------------
// Positional list store controller
// Sequences load, single-word issue and read runs.
// ---------------------------------------------------------------------------
`default_nettype none

module plst_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire plst_pkg::dp_stat_t stat,
  output plst_pkg::ctl_cmd_t      cmd
);
  import plst_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_ISSUE;
      end
      S_ISSUE: begin
        if (stat.out_free) begin
          if (stat.read_ok && !stat.read_last) state_next = S_RUN;
          else state_next = S_IDLE;
        end
      end
      S_RUN: begin
        if (stat.out_free && stat.read_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      S_ISSUE: begin
        cmd.modify    = stat.out_free && !stat.read_ok;
        cmd.emit_read = stat.out_free && stat.read_ok;
      end
      S_RUN: begin
        cmd.emit_read = stat.out_free;
      end
      default: req_stall = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/plst_dpath.sv =====
// ---------------------------------------------------------------------------
// Positional list store datapath
// Entry array, count, word latch, read pointer and output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module plst_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire plst_pkg::ctl_cmd_t              cmd,
  output plst_pkg::dp_stat_t                   stat,
  input  wire logic [1:0]                      op,
  input  wire logic [plst_pkg::POS_W-1:0]      position,
  input  wire logic [plst_pkg::POS_W-1:0]      range_end,
  input  wire logic [plst_pkg::VAL_W-1:0]      item_value,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output logic [1:0]                           status,
  output logic [plst_pkg::VAL_W-1:0]           read_value,
  output logic                                 last_of_run,
  output logic [plst_pkg::POS_W-1:0]           entry_count
);
  import plst_pkg::*;

  logic [DATA_WIDTH-1:0] entries [CAPACITY];
  logic [POS_W-1:0]      count, count_next;
  logic [1:0]            op_q;
  logic [POS_W-1:0]      pos_q, end_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [IDX_W-1:0]      idx;

  logic ins_bad, full, erase_bad, read_bad;
  logic ins_ok, ers_ok;
  logic [1:0] single_status;

  assign ins_bad   = pos_q > count;
  assign full      = count >= POS_W'(CAPACITY);
  assign erase_bad = pos_q >= count;
  assign read_bad  = (pos_q >= count) || (end_q >= count) || (pos_q > end_q);
  assign ins_ok    = (op_q == OP_INSERT) && !ins_bad && !full;
  assign ers_ok    = (op_q == OP_ERASE) && !erase_bad;

  assign stat.read_ok   = (op_q == OP_READ) && !read_bad;
  assign stat.read_last = idx == end_q[IDX_W-1:0];
  assign stat.out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    single_status = ST_BADPOS;
    unique case (op_q)
      OP_INSERT: begin
        priority if (ins_bad) single_status = ST_BADPOS;
        else if (full) single_status = ST_FULL;
        else single_status = ST_OK;
      end
      OP_ERASE: single_status = erase_bad ? ST_BADPOS : ST_OK;
      default: single_status = ST_BADPOS;
    endcase
  end

  always_comb begin
    count_next = count;
    if (ins_ok) count_next = count + POS_W'(1);
    else if (ers_ok) count_next = count - POS_W'(1);
  end

  // latch the word, or step the read pointer on each emitted read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op;
      pos_q <= position;
      end_q <= range_end;
      val_q <= DATA_WIDTH'(item_value);
      idx   <= position[IDX_W-1:0];
    end else if (cmd.emit_read) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.modify) begin
      count <= count_next;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
    localparam logic [POS_W-1:0] GP = POS_W'(g);
    logic [DATA_WIDTH-1:0] below, above;
    if (g == 0) begin : g_first
      assign below = '0;
    end else begin : g_below
      assign below = entries[g-1];
    end
    if (g == CAPACITY - 1) begin : g_top
      assign above = '0;
    end else begin : g_above
      assign above = entries[g+1];
    end
    always_ff @(posedge clk) begin
      if (cmd.modify) begin
        if (ins_ok) begin
          if (GP == pos_q) entries[g] <= val_q;
          else if (GP > pos_q && GP <= count) entries[g] <= below;
        end else if (ers_ok && GP >= pos_q && (GP + POS_W'(1)) < count) begin
          entries[g] <= above;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.modify || cmd.emit_read) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.modify) begin
      status      <= single_status;
      read_value  <= '0;
      last_of_run <= 1'b1;
      entry_count <= count_next;
    end else if (cmd.emit_read) begin
      status      <= ST_OK;
      read_value  <= VAL_W'(entries[idx]);
      last_of_run <= stat.read_last;
      entry_count <= count;
    end
  end

  `ASSERT_AT(a_emit_free, clk, rst, (cmd.modify || cmd.emit_read) |-> stat.out_free)
  `ASSERT_AT(a_count_hold, clk, rst, !cmd.modify |=> $stable(count))
  `ASSERT_AT(a_read_in_list, clk, rst, cmd.emit_read |-> (POS_W'(idx) < count))
  `ASSERT_NEVER(a_count_max, clk, rst, count > POS_W'(CAPACITY))

endmodule

`default_nettype wire

// ===== rtl/core/positional_list_store_unit.sv =====
// ---------------------------------------------------------------------------
// Positional list store unit
// Ordered list of up to CAPACITY words with insert, erase and range read.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall) carries one word: op, position,
//   range_end and item_value. Response channel (rsp_valid/rsp_stall) carries
//   status, read_value, last_of_run and entry_count.
//   Insert, erase, an error or an unused op give one response word, with
//   last_of_run set. A read range gives one word per entry, the last marked.
//   The first response word is registered once the accepted word is issued.
//   Each request word is accepted, then issued, before the next is taken;
//   a read run sends its entries one after another, set by the single
//   read port on the entry array feeding the output register.
//   A request is taken while an earlier response still waits in the output
//   register; a stalled response holds, and issue waits for it to be taken.
//   Reset empties the list (count zero) and drops any pending response;
//   entry contents are left as they are.
// ---------------------------------------------------------------------------
`default_nettype none

module positional_list_store_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_stall,
  input  wire logic [1:0]                 op,
  input  wire logic [plst_pkg::POS_W-1:0] position,
  input  wire logic [plst_pkg::POS_W-1:0] range_end,
  input  wire logic [plst_pkg::VAL_W-1:0] item_value,
  output logic                            rsp_valid,
  input  wire logic                       rsp_stall,
  output logic [1:0]                      status,
  output logic [plst_pkg::VAL_W-1:0]      read_value,
  output logic                            last_of_run,
  output logic [plst_pkg::POS_W-1:0]      entry_count
);
  import plst_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  plst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  plst_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .op          (op),
    .position    (position),
    .range_end   (range_end),
    .item_value  (item_value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .read_value  (read_value),
    .last_of_run (last_of_run),
    .entry_count (entry_count)
  );

endmodule

`default_nettype wire

// ===== dv/positional_list_store_unit_test.sv =====
// ---------------------------------------------------------------------------
// Positional list store unit testbench
// Drives insert, erase and range-read words into the list store and checks
// every response word against a local list predictor. A short directed run
// covers empty, full and bad-position cases. Random traffic follows under
// four idle/stall mixes, with a full drain between them.
// ---------------------------------------------------------------------------
`default_nettype none

module positional_list_store_unit_test;
  import plst_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         PHASE_WORDS  = 75;
  localparam int         MAX_PRINTS   = 40;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] value;
    logic             last;
    logic [POS_W-1:0] count;
  } rsp_word_t;

  class list_scoreboard;
    logic [DATA_WIDTH-1:0] slots [CAPACITY];
    logic [POS_W-1:0]      fill;
    rsp_word_t             pending [$];
    int unsigned           errors;

    function new();
      fill   = '0;
      errors = 0;
    endfunction

    function void push_word(logic [1:0] st, logic [VAL_W-1:0] v, logic last);
      rsp_word_t w;
      w.status = st;
      w.value  = v;
      w.last   = last;
      w.count  = fill;
      pending.push_back(w);
    endfunction

    function void note_word(logic [1:0] o, logic [POS_W-1:0] p, logic [POS_W-1:0] e,
                            logic [VAL_W-1:0] v);
      case (o)
        OP_INSERT: begin
          if (p > fill) begin
            push_word(ST_BADPOS, '0, 1'b1);
          end else if (fill == CAPACITY) begin
            push_word(ST_FULL, '0, 1'b1);
          end else begin
            for (int i = int'(fill); i > int'(p); i--)
              slots[IDX_W'(i)] = slots[IDX_W'(i-1)];
            slots[p[IDX_W-1:0]] = v[DATA_WIDTH-1:0];
            fill++;
            push_word(ST_OK, '0, 1'b1);
          end
        end
        OP_ERASE: begin
          if (p >= fill) begin
            push_word(ST_BADPOS, '0, 1'b1);
          end else begin
            for (int i = int'(p); i + 1 < int'(fill); i++)
              slots[IDX_W'(i)] = slots[IDX_W'(i+1)];
            fill--;
            push_word(ST_OK, '0, 1'b1);
          end
        end
        OP_READ: begin
          if (p >= fill || e >= fill || p > e) begin
            push_word(ST_BADPOS, '0, 1'b1);
          end else begin
            for (int i = int'(p); i <= int'(e); i++)
              push_word(ST_OK, slots[IDX_W'(i)], i == int'(e));
          end
        end
        default: push_word(ST_BADPOS, '0, 1'b1);
      endcase
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_word(logic [1:0] st, logic [VAL_W-1:0] v, logic last, logic [POS_W-1:0] cnt);
      rsp_word_t w;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word status=%0d value=%h", st, v));
        return;
      end
      w = pending.pop_front();
      if (st !== w.status)
        report($sformatf("status got %0d want %0d", st, w.status));
      if (v !== w.value)
        report($sformatf("read_value got %h want %h", v, w.value));
      if (last !== w.last)
        report($sformatf("last_of_run got %b want %b", last, w.last));
      if (cnt !== w.count)
        report($sformatf("entry_count got %0d want %0d", cnt, w.count));
    endtask
  endclass

  logic             clk        = 1'b0;
  logic             rst        = 1'b1;
  logic             req_valid  = 1'b0;
  logic             req_stall;
  logic [1:0]       op         = OP_INSERT;
  logic [POS_W-1:0] position   = '0;
  logic [POS_W-1:0] range_end  = '0;
  logic [VAL_W-1:0] item_value = '0;
  logic             rsp_valid;
  logic             rsp_stall  = 1'b0;
  logic [1:0]       status;
  logic [VAL_W-1:0] read_value;
  logic             last_of_run;
  logic [POS_W-1:0] entry_count;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  list_scoreboard sb = new();

  positional_list_store_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .op         (op),
    .position   (position),
    .range_end  (range_end),
    .item_value (item_value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .read_value (read_value),
    .last_of_run(last_of_run),
    .entry_count(entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0)
      sb.check_word(status, read_value, last_of_run, entry_count);
  end

  task automatic send_word(input logic [1:0] o, input logic [POS_W-1:0] p,
                           input logic [POS_W-1:0] e, input logic [VAL_W-1:0] v);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    req_valid  <= 1'b1;
    op         <= o;
    position   <= p;
    range_end  <= e;
    item_value <= v;
    do @(posedge clk); while (req_stall !== 1'b0);
    sb.note_word(o, p, e, v);
  endtask

  // hold off until every expected word is back
  task automatic drain;
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_word;
    logic [1:0]       o;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] e;
    logic [VAL_W-1:0] v;
    int               n;
    int               pick;
    int               span;
    n    = int'(sb.fill);
    pick = $urandom_range(99);
    v    = $urandom;
    case ($urandom_range(7))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    e = POS_W'($urandom_range(31));
    if (pick < 12) begin
      o = 2'($urandom_range(3));
      p = POS_W'($urandom_range(31));
    end else begin
      if (n == 0) begin
        o = OP_INSERT;
      end else if (n == CAPACITY) begin
        o = (pick < 22) ? OP_INSERT : ((pick < 60) ? OP_ERASE : OP_READ);
      end else begin
        pick = $urandom_range(99);
        if (pick < ((n < 8) ? 55 : 30)) o = OP_INSERT;
        else if (pick < 70) o = OP_ERASE;
        else o = OP_READ;
      end
      case (o)
        OP_INSERT: p = POS_W'($urandom_range(n));
        OP_ERASE:  p = POS_W'($urandom_range(n - 1));
        default: begin
          p    = POS_W'($urandom_range(n - 1));
          span = n - 1 - int'(p);
          e    = POS_W'(int'(p) + int'($urandom_range((span < 3) ? span : 3)));
          if ($urandom_range(9) == 0) begin
            p = '0;
            e = POS_W'(n - 1);
          end
        end
      endcase
    end
    send_word(o, p, e, v);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(OP_READ, '0, '0, '0);
    send_word(OP_ERASE, '0, '0, '0);
    send_word(OP_INSERT, POS_W'(1), '0, '1);
    send_word(OP_UNUSED, POS_W'(31), POS_W'(31), '1);
    send_word(OP_INSERT, '0, '0, '1);
    send_word(OP_INSERT, '0, '0, '0);
    while (sb.fill < CAPACITY)
      send_word(OP_INSERT, POS_W'($urandom_range(sb.fill)), POS_W'($urandom_range(31)),
                $urandom);
    send_word(OP_INSERT, POS_W'(16), '0, 32'h5a5a_5a5a);
    send_word(OP_INSERT, POS_W'(17), '0, '0);
    send_word(OP_READ, '0, POS_W'(15), '0);
    send_word(OP_READ, POS_W'(15), POS_W'(15), '0);
    send_word(OP_READ, POS_W'(3), POS_W'(2), '0);
    send_word(OP_READ, '0, POS_W'(16), '0);
    send_word(OP_ERASE, POS_W'(16), '0, '0);
    send_word(OP_ERASE, POS_W'(15), '0, '0);
    send_word(OP_ERASE, '0, '0, '0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      repeat (PHASE_WORDS) random_word();
      drain();
    end

    if (sb.errors == 0)
      $display("positional_list_store_unit_test passed");
    else
      $display("positional_list_store_unit_test failed");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("positional_list_store_unit_test failed");
    $finish;
  end

endmodule

`default_nettype wire
